[rtl/p4x_pkg.sv]
// Shared constants and types for the Philox-4x32 generator.
`timescale 1ns / 1ps

package p4x_pkg;

   // Number of rounds; one round cell is built for each.
   localparam int ROUND_COUNT = 10;

   // Round multipliers and Weyl key increments.
   localparam logic [31:0] MUL_A  = 32'hD2511F53;
   localparam logic [31:0] MUL_B  = 32'hCD9E8D57;
   localparam logic [31:0] WEYL_A = 32'h9E3779B9;
   localparam logic [31:0] WEYL_B = 32'hBB67AE85;

   // Configuration port widths.
   localparam int CSR_INDEX_WIDTH = 8;
   localparam int CSR_DATA_WIDTH  = 64;

   // Configuration register indexes.
   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_COUNTER_LOW  = 8'd0,
      CSR_COUNTER_HIGH = 8'd1,
      CSR_KEY_WORD0    = 8'd2,
      CSR_KEY_WORD1    = 8'd3
   } csr_reg_type;

   // Data handed from one stage of the chain to the next.
   typedef struct packed {
      logic [31:0] x0;
      logic [31:0] x1;
      logic [31:0] x2;
      logic [31:0] x3;
      logic [31:0] key_a;
      logic [31:0] key_b;
      logic        last;
   } p4x_beat_type;

endpackage

[rtl/philox_4x32_10_generator.sv]
// Top level of the Philox-4x32 generator: counter stage followed by a chain of round cells.
//
//   Channel | Direction | Handshake            | Payload
//   req     | in        | req_valid/req_ready  | req_draw_index, req_last_in
//   rsp     | out       | rsp_valid/rsp_ready  | rsp_word0..3, rsp_last_out
//   csr     | in        | csr_valid/csr_ready  | csr_index, csr_wdata
//
// One draw is taken per cycle while the output is not stalled; a result passes through the
// counter add register and then one register per round cell.
// Every stage has its own register and valid bit, so a stalled output holds only the
// stages behind it that are full; empty stages keep filling.
// Synchronous reset empties the chain and clears the configuration to zero.
// csr_ready is always high.
`timescale 1ns / 1ps

module philox_4x32_10_generator
   import p4x_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [31:0]                req_draw_index,
   input  logic                       req_last_in,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [31:0]                rsp_word0,
   output logic [31:0]                rsp_word1,
   output logic [31:0]                rsp_word2,
   output logic [31:0]                rsp_word3,
   output logic                       rsp_last_out
);

   // Links between stages: link 0 leaves the counter stage, link ROUND_COUNT the last cell.
   logic         link_valid [ROUND_COUNT+1];
   logic         link_ready [ROUND_COUNT+1];
   p4x_beat_type link_beat  [ROUND_COUNT+1];

   // Counter add stage with the configuration registers.
   p4x_ctr_stage u_ctr (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .in_valid      (req_valid),
      .in_ready      (req_ready),
      .in_draw_index (req_draw_index),
      .in_last       (req_last_in),
      .out_valid     (link_valid[0]),
      .out_ready     (link_ready[0]),
      .out_beat      (link_beat[0])
   );

   // One cell per round.
   for (genvar r = 0; r < ROUND_COUNT; r++) begin : g_round
      p4x_round_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[r]),
         .in_ready  (link_ready[r]),
         .in_beat   (link_beat[r]),
         .out_valid (link_valid[r+1]),
         .out_ready (link_ready[r+1]),
         .out_beat  (link_beat[r+1])
      );
   end

   // The last cell's register is the result register.
   assign link_ready[ROUND_COUNT] = rsp_ready;
   assign rsp_valid    = link_valid[ROUND_COUNT];
   assign rsp_word0    = link_beat[ROUND_COUNT].x0;
   assign rsp_word1    = link_beat[ROUND_COUNT].x1;
   assign rsp_word2    = link_beat[ROUND_COUNT].x2;
   assign rsp_word3    = link_beat[ROUND_COUNT].x3;
   assign rsp_last_out = link_beat[ROUND_COUNT].last;

   // An accepted request lands in the counter stage with its last mark.
   a_req_lands : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (link_valid[0] && link_beat[0].last == $past(req_last_in)))
      else $error("accepted request did not reach the counter stage");

   // A full counter stage that cannot move keeps its beat.
   a_ctr_holds : assert property (@(posedge clock) disable iff (reset)
      (link_valid[0] && !link_ready[0]) |=> (link_valid[0] && $stable(link_beat[0])))
      else $error("stalled counter stage lost its beat");

   // A beat offered by the first cell while the second is blocked stays put.
   a_cell_holds : assert property (@(posedge clock) disable iff (reset)
      (link_valid[1] && !link_ready[1]) |=> (link_valid[1] && $stable(link_beat[1])))
      else $error("stalled round cell lost its beat");

   // The counter stage and the output are empty in the cycle after a reset cycle.
   a_reset_empty : assert property (@(posedge clock)
      reset |=> (!rsp_valid && !link_valid[0]))
      else $error("chain not empty after reset");

endmodule

[rtl/p4x_ctr_stage.sv]
// Configuration registers and the counter add stage that feeds the round chain.
`timescale 1ns / 1ps

module p4x_ctr_stage
   import p4x_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   // Configuration writes.
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   // Incoming draw requests.
   input  logic                       in_valid,
   output logic                       in_ready,
   input  logic [31:0]                in_draw_index,
   input  logic                       in_last,
   // Beat towards the first round cell.
   output logic                       out_valid,
   input  logic                       out_ready,
   output p4x_beat_type               out_beat
);

   logic [63:0]  counter_low_ff;
   logic [63:0]  counter_high_ff;
   logic [31:0]  key_word0_ff;
   logic [31:0]  key_word1_ff;
   logic         valid_ff;
   logic         valid_in;
   p4x_beat_type beat_ff;
   p4x_beat_type beat_in;
   logic [64:0]  lo_sum;
   logic [63:0]  hi_sum;
   logic         csr_write;

   // Writes are always taken.
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;

   // Configuration registers; indexes beyond the list are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         counter_low_ff  <= '0;
         counter_high_ff <= '0;
         key_word0_ff    <= '0;
         key_word1_ff    <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_COUNTER_LOW:  counter_low_ff  <= csr_wdata;
            CSR_COUNTER_HIGH: counter_high_ff <= csr_wdata;
            CSR_KEY_WORD0:    key_word0_ff    <= csr_wdata[31:0];
            CSR_KEY_WORD1:    key_word1_ff    <= csr_wdata[31:0];
            default: ;
         endcase
      end
   end

   // The stage takes a new beat whenever it is empty or its beat moves on.
   assign in_ready = ~valid_ff | out_ready;

   // Base counter plus index, wrapping modulo 2^128. The keys are pre-decremented
   // so that every round cell can apply the same Weyl bump.
   always_comb begin
      lo_sum          = {1'b0, counter_low_ff} + {33'd0, in_draw_index};
      hi_sum          = counter_high_ff + {63'd0, lo_sum[64]};
      beat_in.x0      = lo_sum[31:0];
      beat_in.x1      = lo_sum[63:32];
      beat_in.x2      = hi_sum[31:0];
      beat_in.x3      = hi_sum[63:32];
      beat_in.key_a   = key_word0_ff - WEYL_A;
      beat_in.key_b   = key_word1_ff - WEYL_B;
      beat_in.last    = in_last;
      valid_in        = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

[rtl/p4x_round_cell.sv]
// One Philox-4x32 round with its own output register and handshake.
`timescale 1ns / 1ps

module p4x_round_cell
   import p4x_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  p4x_beat_type in_beat,
   output logic         out_valid,
   input  logic         out_ready,
   output p4x_beat_type out_beat
);

   logic         valid_ff;
   logic         valid_in;
   p4x_beat_type beat_ff;
   p4x_beat_type beat_in;
   logic [31:0]  key_a;
   logic [31:0]  key_b;
   logic [63:0]  prod_a;
   logic [63:0]  prod_b;

   assign in_ready = ~valid_ff | out_ready;

   // Key bump, the two multiplies and the XOR mixing of one round.
   always_comb begin
      key_a         = in_beat.key_a + WEYL_A;
      key_b         = in_beat.key_b + WEYL_B;
      prod_a        = {32'd0, MUL_A} * {32'd0, in_beat.x0};
      prod_b        = {32'd0, MUL_B} * {32'd0, in_beat.x2};
      beat_in.x0    = prod_b[63:32] ^ in_beat.x1 ^ key_a;
      beat_in.x1    = prod_b[31:0];
      beat_in.x2    = prod_a[63:32] ^ in_beat.x3 ^ key_b;
      beat_in.x3    = prod_a[31:0];
      beat_in.key_a = key_a;
      beat_in.key_b = key_b;
      beat_in.last  = in_beat.last;
      valid_in      = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid & in_ready) begin
         beat_ff <= beat_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_beat  = beat_ff;

endmodule

[tb/sv/philox_draw_checker.sv]
// Checker for the Philox-4x32 generator: predicts every draw and compares the result beats.
`timescale 1ns / 1ps

module philox_draw_checker
   import p4x_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0]  csr_wdata,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [31:0]                req_draw_index,
   input  logic                       req_last_in,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [31:0]                rsp_word0,
   input  logic [31:0]                rsp_word1,
   input  logic [31:0]                rsp_word2,
   input  logic [31:0]                rsp_word3,
   input  logic                       rsp_last_out,
   output int                         error_count,
   output int                         pending_count
);

   // One four-word draw together with its job mark.
   typedef struct packed {
      logic [31:0] word0;
      logic [31:0] word1;
      logic [31:0] word2;
      logic [31:0] word3;
      logic        last;
   } draw_words_type;

   // Shadow copy of the configuration registers.
   logic [63:0] base_counter_low;
   logic [63:0] base_counter_high;
   logic [31:0] key_lane_a;
   logic [31:0] key_lane_b;

   draw_words_type expected_draws[$];
   int             mismatches;

   assign error_count = mismatches;

   // Offsets the base counter by the draw index and scrambles the sum with the Philox rounds.
   function automatic draw_words_type philox_scramble(input logic [31:0] draw_index,
                                                      input logic        last);
      logic [127:0]   ctr;
      logic [31:0]    x0, x1, x2, x3, ka, kb;
      logic [63:0]    prod_a, prod_b;
      draw_words_type outcome;
      ctr = {base_counter_high, base_counter_low} + {96'd0, draw_index};
      x0  = ctr[31:0];
      x1  = ctr[63:32];
      x2  = ctr[95:64];
      x3  = ctr[127:96];
      ka  = key_lane_a;
      kb  = key_lane_b;
      for (int r = 0; r < ROUND_COUNT; r++) begin
         // The key is bumped before every round but the first.
         if (r != 0) begin
            ka = ka + WEYL_A;
            kb = kb + WEYL_B;
         end
         prod_a = {32'd0, MUL_A} * {32'd0, x0};
         prod_b = {32'd0, MUL_B} * {32'd0, x2};
         x0 = prod_b[63:32] ^ x1 ^ ka;
         x2 = prod_a[63:32] ^ x3 ^ kb;
         x1 = prod_b[31:0];
         x3 = prod_a[31:0];
      end
      outcome.word0 = x0;
      outcome.word1 = x1;
      outcome.word2 = x2;
      outcome.word3 = x3;
      outcome.last  = last;
      return outcome;
   endfunction

   // Prints one mismatch line and counts it.
   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("%0t philox_draw_checker: %s got %h, expected %h", $realtime, what, got, want);
      mismatches++;
   endtask

   // Watches all three channels at each rising edge.
   always @(posedge clock) begin
      draw_words_type want;
      if (reset) begin
         base_counter_low  = '0;
         base_counter_high = '0;
         key_lane_a        = '0;
         key_lane_b        = '0;
         expected_draws.delete();
      end else begin
         // Result beat: compared with the oldest outstanding draw.
         if (rsp_valid && rsp_ready) begin
            if (expected_draws.size() == 0) begin
               report_mismatch("unexpected result beat, word0", rsp_word0, 32'd0);
            end else begin
               want = expected_draws.pop_front();
               if (rsp_word0 !== want.word0) report_mismatch("word0", rsp_word0, want.word0);
               if (rsp_word1 !== want.word1) report_mismatch("word1", rsp_word1, want.word1);
               if (rsp_word2 !== want.word2) report_mismatch("word2", rsp_word2, want.word2);
               if (rsp_word3 !== want.word3) report_mismatch("word3", rsp_word3, want.word3);
               if (rsp_last_out !== want.last) begin
                  report_mismatch("last_out", {31'd0, rsp_last_out}, {31'd0, want.last});
               end
            end
         end
         // Register write: unknown indexes are ignored, key writes keep the low word.
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_COUNTER_LOW:  base_counter_low  = csr_wdata;
               CSR_COUNTER_HIGH: base_counter_high = csr_wdata;
               CSR_KEY_WORD0:    key_lane_a        = csr_wdata[31:0];
               CSR_KEY_WORD1:    key_lane_b        = csr_wdata[31:0];
               default: ;
            endcase
         end
         // Request beat: the draw is predicted under the configuration in force.
         if (req_valid && req_ready) begin
            expected_draws.push_back(philox_scramble(req_draw_index, req_last_in));
         end
      end
      pending_count <= expected_draws.size();
   end

endmodule

[tb/sv/tb_top.sv]
// Top of the Philox-4x32 generator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb_top
   import p4x_pkg::*;
();

   localparam int LATENCY = ROUND_COUNT + 1;

   logic                       clock          = 1'b0;
   logic                       reset          = 1'b1;
   logic                       csr_valid      = 1'b0;
   logic                       csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index      = '0;
   logic [CSR_DATA_WIDTH-1:0]  csr_wdata      = '0;
   logic                       req_valid      = 1'b0;
   logic                       req_ready;
   logic [31:0]                req_draw_index = '0;
   logic                       req_last_in    = 1'b0;
   logic                       rsp_valid;
   logic                       rsp_ready      = 1'b0;
   logic [31:0]                rsp_word0, rsp_word1, rsp_word2, rsp_word3;
   logic                       rsp_last_out;

   int error_count;
   int pending_count;
   int send_idle = 30;
   int recv_idle = 57;

   philox_4x32_10_generator uut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_draw_index (req_draw_index),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word0      (rsp_word0),
      .rsp_word1      (rsp_word1),
      .rsp_word2      (rsp_word2),
      .rsp_word3      (rsp_word3),
      .rsp_last_out   (rsp_last_out)
   );

   philox_draw_checker checker_i (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_draw_index (req_draw_index),
      .req_last_in    (req_last_in),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_word0      (rsp_word0),
      .rsp_word1      (rsp_word1),
      .rsp_word2      (rsp_word2),
      .rsp_word3      (rsp_word3),
      .rsp_last_out   (rsp_last_out),
      .error_count    (error_count),
      .pending_count  (pending_count)
   );

   // 4 ns clock.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // The receiver stalls at random according to the current idle share.
   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle);
   end

   // Hard limit on the run time.
   initial begin
      #2ms;
      $display("tb_top: errors");
      $finish;
   end

   // Presents one draw beat, with random idle cycles ahead of it, and waits for acceptance.
   task automatic send_draw(input logic [31:0] draw_index, input logic last);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_draw_index <= draw_index;
      req_last_in    <= last;
      do @(posedge clock); while (!req_ready);
   endtask

   // Writes one register; the caller lowers csr_valid after the last write of a batch.
   task automatic write_csr(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [CSR_DATA_WIDTH-1:0]  data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   // Ends a burst of draws and waits until every result has come out of the chain.
   task automatic drain_draws();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   // Picks a base counter and key, with the extremes and near-wrap counters favoured.
   task automatic load_setting();
      logic [63:0] lo, hi;
      case ($urandom_range(3))
         0: begin
            lo = '0;
            hi = '0;
         end
         1: begin
            lo = '1;
            hi = '1;
         end
         2: begin
            lo = ~{32'd0, $urandom_range(255)};
            hi = ($urandom_range(1) != 0) ? '1 : {$urandom, $urandom};
         end
         default: begin
            lo = {$urandom, $urandom};
            hi = {$urandom, $urandom};
         end
      endcase
      // A write to an index beyond the register list must change nothing.
      write_csr(CSR_INDEX_WIDTH'($urandom_range(4, 255)), {$urandom, $urandom});
      write_csr(CSR_COUNTER_LOW, lo);
      write_csr(CSR_COUNTER_HIGH, hi);
      write_csr(CSR_KEY_WORD0, {$urandom, $urandom});
      write_csr(CSR_KEY_WORD1, {$urandom, $urandom});
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Draw indexes lean towards both ends so that carries into the upper words occur.
   function automatic logic [31:0] random_draw_index();
      case ($urandom_range(3))
         0:       return 32'($urandom_range(15));
         1:       return 32'hFFFF_FFFF - 32'($urandom_range(15));
         default: return $urandom;
      endcase
   endfunction

   // Stimulus: directed draws, then random bursts under changing settings and idle shares.
   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset configuration: all zero counter and key.
      send_draw(32'h0000_0000, 1'b0);
      send_draw(32'hFFFF_FFFF, 1'b1);
      send_draw(32'h0000_0001, 1'b0);
      drain_draws();

      // Everything at its top value; key writes carry junk in the upper half.
      write_csr(CSR_COUNTER_LOW, '1);
      write_csr(CSR_COUNTER_HIGH, '1);
      write_csr(CSR_KEY_WORD0, 64'hDEAD_BEEF_FFFF_FFFF);
      write_csr(CSR_KEY_WORD1, '1);
      write_csr(8'd4, '0);
      write_csr(8'hFF, '0);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_draw(32'h0000_0000, 1'b0);
      send_draw(32'h0000_0001, 1'b0);
      send_draw(32'hFFFF_FFFF, 1'b0);
      send_draw(32'h8000_0000, 1'b1);
      drain_draws();

      // Carry out of the lowest word only.
      write_csr(CSR_COUNTER_LOW, 64'h0000_0000_FFFF_FFFF);
      write_csr(CSR_COUNTER_HIGH, '0);
      write_csr(CSR_KEY_WORD0, '0);
      write_csr(CSR_KEY_WORD1, 64'hFFFF_FFFF_0000_0000);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_draw(32'h0000_0001, 1'b0);
      send_draw(32'hFFFF_FFFF, 1'b1);
      drain_draws();

      // Carry from the low half into the high half, then across into the top word.
      write_csr(CSR_COUNTER_LOW, '1);
      write_csr(CSR_COUNTER_HIGH, 64'h0000_0000_FFFF_FFFF);
      csr_valid <= 1'b0;
      @(posedge clock);
      send_draw(32'h0000_0001, 1'b0);
      send_draw(32'h0000_0000, 1'b0);
      send_draw(32'h0000_0002, 1'b1);
      drain_draws();

      // Random bursts: sender lighter first, then receiver lighter, then no idling at all.
      for (int seg = 0; seg < 8; seg++) begin
         if (seg == 3) begin
            send_idle = 57;
            recv_idle = 30;
         end else if (seg == 6) begin
            send_idle = 0;
            recv_idle = 0;
         end
         load_setting();
         for (int n = 0; n < 100; n++) begin
            send_draw(random_draw_index(), ($urandom_range(7) == 0));
         end
         drain_draws();
      end

      if (error_count == 0 && pending_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

[sim.f]
rtl/p4x_pkg.sv
rtl/p4x_ctr_stage.sv
rtl/p4x_round_cell.sv
rtl/philox_4x32_10_generator.sv
tb/sv/philox_draw_checker.sv
tb/sv/tb_top.sv
